>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mcds_pkg.sv
// ---------------------------------------------------------------------------
// mcds_pkg
// Types, operation codes and helpers of the minimum cost split solver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcds_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int COEF_WIDTH = DATA_WIDTH + 2;
  localparam int CNT_WIDTH  = $clog2(2 * DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0]        word_t;
  typedef logic [2*DATA_WIDTH-1:0]      dword_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef struct packed {
    word_t total;
    word_t cost_first;
    word_t size_first;
    word_t cost_second;
    word_t size_second;
  } req_t;

  typedef struct packed {
    logic  feasible;
    word_t count_first;
    word_t count_second;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_START, OP_FIN_ZZ, OP_DIV_NB, OP_FIN_A0, OP_DIV_NA, OP_FIN_B0,
    OP_EU_INIT, OP_EU_DIV, OP_EU_MUL, OP_EU_UPD, OP_DIV_GN, OP_FIN_FAIL,
    OP_DIV_GA, OP_DIV_GB, OP_DIV_NRB, OP_DIV_TB, OP_MUL_X, OP_DIV_X,
    OP_DIV_NRA, OP_DIV_SA, OP_MUL_Y, OP_DIV_Y, OP_MUL_CHK, OP_DIV_YMAX,
    OP_DIV_XMAX, OP_MUL_COST, OP_FIN_OK
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic a_zero;
    logic b_zero;
    logic r1_zero;
    logic rem_zero;
    logic le;
  } stat_t;

  function automatic logic op_is_div(op_t op);
    case (op) inside
      OP_DIV_NB, OP_DIV_NA, OP_EU_DIV, OP_DIV_GN, OP_DIV_GA, OP_DIV_GB,
      OP_DIV_NRB, OP_DIV_TB, OP_DIV_X, OP_DIV_NRA, OP_DIV_SA, OP_DIV_Y,
      OP_DIV_YMAX, OP_DIV_XMAX: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_is_mul(op_t op);
    case (op) inside
      OP_EU_MUL, OP_MUL_X, OP_MUL_Y, OP_MUL_CHK, OP_MUL_COST: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_is_fin(op_t op);
    case (op) inside
      OP_FIN_ZZ, OP_FIN_A0, OP_FIN_B0, OP_FIN_FAIL, OP_FIN_OK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

>>> rtl/mcds_div.sv
// ---------------------------------------------------------------------------
// mcds_div
// Restoring divider, one quotient bit a cycle, narrow or double-width dividend.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcds_div import mcds_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  logic   wide,
  input  dword_t dividend,
  input  word_t  divisor,
  output dword_t quot,
  output word_t  rem,
  output logic   done
);

  logic [CNT_WIDTH-1:0]  cnt;
  logic                  busy;
  dword_t                dq;
  word_t                 rem_r;
  word_t                 dvs;
  logic [DATA_WIDTH:0]   part;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // A narrow dividend sits in the upper half so that DATA_WIDTH steps suffice.
  assign part = {rem_r, dq[2*DATA_WIDTH-1]};
  assign ge   = part >= {1'b0, dvs};
  assign diff = part - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= wide ? CNT_WIDTH'(2 * DATA_WIDTH) : CNT_WIDTH'(DATA_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= wide ? dividend : {dividend[DATA_WIDTH-1:0], {DATA_WIDTH{1'b0}}};
      rem_r <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      if (ge) begin
        rem_r <= diff[DATA_WIDTH-1:0];
        dq    <= {dq[2*DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= part[DATA_WIDTH-1:0];
        dq    <= {dq[2*DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quot = dq;
  assign rem  = rem_r;

endmodule

>>> rtl/mcds_mul.sv
// ---------------------------------------------------------------------------
// mcds_mul
// Shift-and-add multiplier, one multiplier bit a cycle, full-width product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcds_mul import mcds_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  word_t  mcand_in,
  input  word_t  mplier_in,
  output dword_t prod,
  output logic   done
);

  logic [CNT_WIDTH-1:0] cnt;
  logic                 busy;
  dword_t               mcand;
  word_t                mplier;
  dword_t               acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(DATA_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= dword_t'(mcand_in);
      mplier <= mplier_in;
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[2*DATA_WIDTH-2:0], 1'b0};
      mplier <= {1'b0, mplier[DATA_WIDTH-1:1]};
    end
  end

  assign prod = acc;

endmodule

>>> rtl/mcds_dp.sv
// ---------------------------------------------------------------------------
// mcds_dp
// Datapath: operand registers, Euclid coefficients, divider and multipliers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcds_dp import mcds_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  req_t  req,
  output stat_t stat,
  output rsp_t  rsp
);

  word_t  n, c1, a, b, c2;
  word_t  r0, r1, q_r, rem_r;
  coef_t  s0, s1, t0, t1;
  dword_t p0, p1;
  word_t  nr, ar, br, red, inv, xmin, ymin, xmax, ymax;
  rsp_t   res;

  logic   div_start, div_wide, div_done, div_neg;
  dword_t div_dividend, div_quot;
  word_t  div_divisor, div_rem;
  logic   mul_start, mul_done, mul1_done;
  word_t  m0_a, m0_b, m1_a, m1_b;
  dword_t m0_p, m1_p;

  function automatic word_t mag(coef_t v);
    coef_t m;
    m = v[COEF_WIDTH-1] ? -v : v;
    return m[DATA_WIDTH-1:0];
  endfunction

  assign div_start = cmd.start && op_is_div(cmd.op);
  assign mul_start = cmd.start && op_is_mul(cmd.op);

  always_comb begin
    div_wide     = 1'b0;
    div_neg      = 1'b0;
    div_dividend = '0;
    div_divisor  = word_t'(1);
    case (cmd.op)
      OP_DIV_NB:   begin div_dividend = dword_t'(n);  div_divisor = b;  end
      OP_DIV_NA:   begin div_dividend = dword_t'(n);  div_divisor = a;  end
      OP_EU_DIV:   begin div_dividend = dword_t'(r0); div_divisor = r1; end
      OP_DIV_GN:   begin div_dividend = dword_t'(n);  div_divisor = r0; end
      OP_DIV_GA:   begin div_dividend = dword_t'(a);  div_divisor = r0; end
      OP_DIV_GB:   begin div_dividend = dword_t'(b);  div_divisor = r0; end
      OP_DIV_NRB:  begin div_dividend = dword_t'(nr); div_divisor = br; end
      OP_DIV_NRA:  begin div_dividend = dword_t'(nr); div_divisor = ar; end
      OP_DIV_TB: begin
        div_dividend = dword_t'(mag(t0));
        div_divisor  = br;
        div_neg      = t0[COEF_WIDTH-1];
      end
      OP_DIV_SA: begin
        div_dividend = dword_t'(mag(s0));
        div_divisor  = ar;
        div_neg      = s0[COEF_WIDTH-1];
      end
      OP_DIV_X:    begin div_dividend = p0; div_divisor = br; div_wide = 1'b1; end
      OP_DIV_Y:    begin div_dividend = p0; div_divisor = ar; div_wide = 1'b1; end
      OP_DIV_YMAX: begin
        div_dividend = dword_t'(nr - p0[DATA_WIDTH-1:0]);
        div_divisor  = br;
      end
      OP_DIV_XMAX: begin
        div_dividend = dword_t'(nr - p1[DATA_WIDTH-1:0]);
        div_divisor  = ar;
      end
      default: ;
    endcase
  end

  always_comb begin
    m0_a = '0;
    m0_b = '0;
    m1_a = '0;
    m1_b = '0;
    case (cmd.op)
      OP_EU_MUL: begin
        m0_a = q_r; m0_b = mag(t1);
        m1_a = q_r; m1_b = mag(s1);
      end
      OP_MUL_X, OP_MUL_Y: begin
        m0_a = red; m0_b = inv;
      end
      OP_MUL_CHK: begin
        m0_a = ar; m0_b = xmin;
        m1_a = br; m1_b = ymin;
      end
      OP_MUL_COST: begin
        m0_a = br; m0_b = c1;
        m1_a = ar; m1_b = c2;
      end
      default: ;
    endcase
  end

  mcds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .wide     (div_wide),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  mcds_mul u_mul0 (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (m0_a),
    .mplier_in (m0_b),
    .prod      (m0_p),
    .done      (mul_done)
  );

  mcds_mul u_mul1 (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (m1_a),
    .mplier_in (m1_b),
    .prod      (m1_p),
    .done      (mul1_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n  <= req.total;
      c1 <= req.cost_first;
      a  <= req.size_first;
      c2 <= req.cost_second;
      b  <= req.size_second;
    end

    if (cmd.start) begin
      case (cmd.op)
        OP_EU_INIT: begin
          r0 <= b;
          r1 <= a;
          s0 <= coef_t'(1);
          s1 <= '0;
          t0 <= '0;
          t1 <= coef_t'(1);
        end
        OP_EU_UPD: begin
          r0 <= r1;
          r1 <= rem_r;
          t0 <= t1;
          s0 <= s1;
          t1 <= t1[COEF_WIDTH-1] ? t0 + coef_t'(p0[COEF_WIDTH-1:0])
                                 : t0 - coef_t'(p0[COEF_WIDTH-1:0]);
          s1 <= s1[COEF_WIDTH-1] ? s0 + coef_t'(p1[COEF_WIDTH-1:0])
                                 : s0 - coef_t'(p1[COEF_WIDTH-1:0]);
        end
        OP_FIN_ZZ:   res <= '{feasible: (n == '0), count_first: '0, count_second: '0};
        OP_FIN_A0:   res <= '{feasible: (rem_r == '0), count_first: '0,
                              count_second: (rem_r == '0) ? q_r : '0};
        OP_FIN_B0:   res <= '{feasible: (rem_r == '0), count_second: '0,
                              count_first: (rem_r == '0) ? q_r : '0};
        OP_FIN_FAIL: res <= '0;
        OP_FIN_OK: begin
          // Equal costs resolve towards the end with more first-kind items.
          if (p0 <= p1) begin
            res <= '{feasible: 1'b1, count_first: xmax, count_second: ymin};
          end else begin
            res <= '{feasible: 1'b1, count_first: xmin, count_second: ymax};
          end
        end
        default: ;
      endcase
    end

    if (div_done) begin
      q_r   <= div_quot[DATA_WIDTH-1:0];
      rem_r <= div_rem;
      case (cmd.op)
        OP_DIV_GN:   nr   <= div_quot[DATA_WIDTH-1:0];
        OP_DIV_GA:   ar   <= div_quot[DATA_WIDTH-1:0];
        OP_DIV_GB:   br   <= div_quot[DATA_WIDTH-1:0];
        OP_DIV_NRB, OP_DIV_NRA: red <= div_rem;
        OP_DIV_TB, OP_DIV_SA: begin
          inv <= (div_neg && div_rem != '0) ? div_divisor - div_rem : div_rem;
        end
        OP_DIV_X:    xmin <= div_rem;
        OP_DIV_Y:    ymin <= div_rem;
        OP_DIV_YMAX: ymax <= div_quot[DATA_WIDTH-1:0];
        OP_DIV_XMAX: xmax <= div_quot[DATA_WIDTH-1:0];
        default: ;
      endcase
    end

    if (mul_done) begin
      p0 <= m0_p;
      p1 <= m1_p;
    end
  end

  // Both multiplier lanes start together and finish together.
  assign stat.done     = div_done | (mul_done & mul1_done);
  assign stat.a_zero   = (a == '0);
  assign stat.b_zero   = (b == '0);
  assign stat.r1_zero  = (r1 == '0);
  assign stat.rem_zero = (rem_r == '0);
  assign stat.le       = (p0 <= dword_t'(nr));

  assign rsp = res;

endmodule

>>> rtl/mcds_ctrl.sv
// ---------------------------------------------------------------------------
// mcds_ctrl
// Sequencer that steps the datapath through the solver operations.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcds_ctrl import mcds_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEP  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_WAIT  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next, op_after;

  always_comb begin
    unique case (op)
      OP_START: begin
        if (stat.a_zero && stat.b_zero) op_after = OP_FIN_ZZ;
        else if (stat.a_zero)           op_after = OP_DIV_NB;
        else if (stat.b_zero)           op_after = OP_DIV_NA;
        else                            op_after = OP_EU_INIT;
      end
      OP_DIV_NB:   op_after = OP_FIN_A0;
      OP_DIV_NA:   op_after = OP_FIN_B0;
      OP_EU_INIT:  op_after = OP_EU_DIV;
      OP_EU_DIV:   op_after = OP_EU_MUL;
      OP_EU_MUL:   op_after = OP_EU_UPD;
      OP_EU_UPD:   op_after = stat.r1_zero ? OP_DIV_GN : OP_EU_DIV;
      OP_DIV_GN:   op_after = stat.rem_zero ? OP_DIV_GA : OP_FIN_FAIL;
      OP_DIV_GA:   op_after = OP_DIV_GB;
      OP_DIV_GB:   op_after = OP_DIV_NRB;
      OP_DIV_NRB:  op_after = OP_DIV_TB;
      OP_DIV_TB:   op_after = OP_MUL_X;
      OP_MUL_X:    op_after = OP_DIV_X;
      OP_DIV_X:    op_after = OP_DIV_NRA;
      OP_DIV_NRA:  op_after = OP_DIV_SA;
      OP_DIV_SA:   op_after = OP_MUL_Y;
      OP_MUL_Y:    op_after = OP_DIV_Y;
      OP_DIV_Y:    op_after = OP_MUL_CHK;
      OP_MUL_CHK:  op_after = stat.le ? OP_DIV_YMAX : OP_FIN_FAIL;
      OP_DIV_YMAX: op_after = OP_DIV_XMAX;
      OP_DIV_XMAX: op_after = OP_MUL_COST;
      OP_MUL_COST: op_after = OP_FIN_OK;
      default:     op_after = OP_FIN_FAIL;
    endcase
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_STEP;
          op_next    = OP_START;
        end
      end
      S_STEP: begin
        state_next = S_ISSUE;
        op_next    = op_after;
      end
      S_ISSUE: begin
        if (op_is_fin(op))                      state_next = S_OUT;
        else if (op_is_div(op) || op_is_mul(op)) state_next = S_WAIT;
        else                                     state_next = S_STEP;
      end
      S_WAIT: begin
        if (stat.done) state_next = S_STEP;
      end
      S_OUT: begin
        if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_START;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign cmd.load  = req_valid && (state == S_IDLE);
  assign cmd.start = (state == S_ISSUE);
  assign cmd.op    = op;

endmodule

>>> rtl/min_cost_diophantine_solver.sv
// ---------------------------------------------------------------------------
// min_cost_diophantine_solver
// Cheapest non-negative split of a total into two kinds of sized items.
// ---------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------
//   request | req_valid, req_ready | req_data  (total, costs, sizes)
//   result  | rsp_valid, rsp_ready | rsp_data  (feasible, two counts)
//
// One transaction is handled at a time; the next request is taken once the
// result transaction has completed. Each remainder step of the extended
// Euclid loop makes one pass of the bit-serial divider, then one of the
// bit-serial multipliers, and the loop is followed by the fifteen or so
// further operations of the solver.
// Reset is synchronous and returns the sequencer to idle; no clearing pass.
// A stalled result simply holds in the output register until taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_cost_diophantine_solver import mcds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

`include "assert_macros.svh"

  // The controller and datapath talk only through these two groups.
  cmd_t  cmd;
  stat_t stat;

  mcds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the Euclid coefficients, the shared
  // divider and two multiplier lanes, and the registered result.
  mcds_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req_data),
    .stat (stat),
    .rsp  (rsp_data)
  );

  // The block never offers a result while it is also taking a request.
  `ASSERT_ALWAYS(a_no_overlap, !(req_ready && rsp_valid), "ready and result valid together")

  // A failed search always reports zero counts.
  `ASSERT_ALWAYS(a_fail_zero, !(rsp_valid && !rsp_data.feasible) ||
                 (rsp_data.count_first == '0 && rsp_data.count_second == '0),
                 "failed result with non-zero counts")

  // A freshly accepted request cannot produce its result in the next cycle.
  `ASSERT_NEXT(a_no_instant, req_valid && req_ready, !rsp_valid, "result too early")

endmodule
